// ----- rtl/core/bpa_pkg.sv -----
// bitmap page allocator: shared types and constants
// used by the allocator top level and its port checker, no dependencies
`default_nettype none

package bpa_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_FREE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_FIT,
        M_ALIGN,
        M_EXT
    } t_mode;

    typedef enum logic [2:0] {
        K_ALLOC   = 3'd0,
        K_FREE    = 3'd1,
        K_ALIGNED = 3'd2,
        K_EXTEND  = 3'd3,
        K_RESERVE = 3'd4,
        K_CLRSTAT = 3'd5
    } t_kind;

    localparam int  CFG_AW         = 3;
    // register index is byte address bit 2
    localparam logic REG_PAGE_LIMIT = 1'b0;
    localparam int  FLAG_NOFREE    = 0;
    localparam int  FLAG_NOSIZE    = 1;
    localparam logic [12:0] PAGE_LIMIT_RST = 13'd4096;

endpackage

`default_nettype wire

// ----- rtl/core/bpa_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/bitmap_page_allocator.sv -----
// bitmap page allocator, first fit, one used bit per page in a 1-bit wide ram
// depends on bpa_pkg and bpa_ram
// steps: free/reserve write their run clipped at the map end, allocate scans the map and
//   writes the run on a grant, extend adds its check and the old-run release
// throughput: one request at a time, one bit per cycle on the single read port; no result stall
// reset: synchronous; a clearing pass marks every page used, busy high
`default_nettype none

module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          i_kind,
    input  wire logic [11:0]         i_page,
    input  wire logic [12:0]         i_count,
    input  wire logic [12:0]         i_prev_count,
    input  wire logic [12:0]         i_align,
    output logic                     o_done,
    output logic                     o_ok,
    output logic [11:0]              o_result_page,
    output logic                     o_moved,
    output logic                     o_no_free_space,
    output logic                     o_size_unavailable,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CFG_AW-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int PW = ((AW > 13) ? AW : 13) + 2;
    localparam logic [PW-1:0] NP   = PW'(NUM_PAGES);
    localparam logic [PW-1:0] LAST = PW'(NUM_PAGES - 1);

    t_state r_state, n_state;
    t_mode  r_mode;
    t_kind  r_kind;
    logic [11:0]   r_page;
    logic [12:0]   r_count, r_prev, r_align, r_page_limit;
    logic [PW-1:0] r_lim, r_ptr, r_chk, r_run, r_cand, r_at, r_wp, r_we;
    logic          r_pend, r_any, r_wval, r_move;
    logic          r_ok, r_mv;
    logic [11:0]   r_rp;
    logic [1:0]    r_flags;

    logic          rd_bit, used, free_now;
    logic [PW-1:0] cand_next, scan_addr, lim_in;
    logic          fit_hit, fit_end, al_hit, al_fail, ext_hit, redirect;
    logic          done_w, in_skip;
    logic          wr_en, wr_data, cfg_wr;
    t_kind         in_kind;

    bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (scan_addr[AW-1:0]),
        .o_rd_data (rd_bit)
    );

    assign in_kind   = t_kind'(i_kind);
    assign lim_in    = (PW'(r_page_limit) > NP) ? NP : PW'(r_page_limit);
    // pages past the end read as used
    assign used      = (r_chk >= NP) | rd_bit;
    assign free_now  = !used;
    assign cand_next = r_cand + PW'(r_align);
    assign fit_hit   = free_now && ((r_run + 1'b1) == PW'(r_count));
    assign fit_end   = (r_chk == LAST);
    assign al_hit    = free_now && ((r_chk + 1'b1) == r_we);
    assign al_fail   = used && (cand_next >= r_lim);
    assign ext_hit   = free_now && ((r_chk + 1'b1) == r_we);
    assign done_w    = (r_wp >= r_we) || (r_wp >= NP);
    assign in_skip   = (r_wp >= r_at) && (r_wp < (r_at + PW'(r_count)));
    assign cfg_wr    = psel && penable && pwrite && pready;

    // read redirect when a candidate fails or extend falls back to first fit
    always_comb begin
        redirect  = 1'b0;
        scan_addr = r_ptr;
        if (r_pend) begin
            if (r_mode == M_ALIGN && used && !al_fail) begin
                redirect  = 1'b1;
                scan_addr = cand_next;
            end else if (r_mode == M_EXT && used) begin
                redirect  = 1'b1;
                scan_addr = '0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_wp == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    unique case (in_kind) inside
                        K_ALLOC:   n_state = (i_count == '0) ? S_DONE : S_SCAN;
                        K_FREE, K_RESERVE: n_state = S_FILL;
                        K_ALIGNED: n_state = (i_align == '0 || i_count == '0 ||
                                              PW'(i_align) >= lim_in) ? S_DONE : S_SCAN;
                        K_EXTEND:  n_state = (i_count <= i_prev_count) ? S_FILL : S_SCAN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    unique case (r_mode)
                        M_FIT: begin
                            if (fit_hit) n_state = S_FILL;
                            else if (fit_end) n_state = S_DONE;
                        end
                        M_ALIGN: begin
                            if (al_hit) n_state = S_FILL;
                            else if (al_fail) n_state = S_DONE;
                        end
                        M_EXT: begin
                            if (ext_hit) n_state = S_FILL;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_FILL: begin
                if (done_w) n_state = r_move ? S_FREE : S_DONE;
            end
            S_FREE: begin
                if (done_w) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and ram write control
    always_comb begin
        busy    = (r_state != S_IDLE);
        o_done  = (r_state == S_DONE);
        wr_en   = 1'b0;
        wr_data = r_wval;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = 1'b1;
            end
            S_FILL:  wr_en = !done_w;
            S_FREE:  wr_en = !done_w && !in_skip;
            default: wr_en = 1'b0;
        endcase
    end

    assign o_ok               = r_ok;
    assign o_result_page      = r_rp;
    assign o_moved            = r_mv;
    assign o_no_free_space    = r_flags[FLAG_NOFREE];
    assign o_size_unavailable = r_flags[FLAG_NOSIZE];
    assign pready             = 1'b1;
    assign prdata = (paddr[2] == REG_PAGE_LIMIT) ? {19'b0, r_page_limit} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_wp         <= '0;
            r_pend       <= 1'b0;
            r_move       <= 1'b0;
            r_flags      <= '0;
            r_page_limit <= PAGE_LIMIT_RST;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr[2] == REG_PAGE_LIMIT) begin
                r_page_limit <= pwdata[12:0];
            end
            unique case (r_state)
                S_CLEAR: r_wp <= r_wp + 1'b1;
                S_IDLE: begin
                    if (start) begin
                        r_kind  <= in_kind;
                        r_page  <= i_page;
                        r_count <= i_count;
                        r_prev  <= i_prev_count;
                        r_align <= i_align;
                        r_lim   <= lim_in;
                        r_mv    <= 1'b0;
                        r_pend  <= 1'b0;
                        r_run   <= '0;
                        r_any   <= 1'b0;
                        r_move  <= 1'b0;
                        r_at    <= '0;
                        unique case (in_kind) inside
                            K_ALLOC: begin
                                r_mode <= M_FIT;
                                r_ptr  <= '0;
                                r_ok   <= 1'b0;
                                r_rp   <= '0;
                            end
                            K_FREE, K_RESERVE: begin
                                r_wp   <= PW'(i_page);
                                r_we   <= PW'(i_page) + PW'(i_count);
                                r_wval <= (in_kind == K_RESERVE);
                                r_ok   <= 1'b1;
                                r_rp   <= i_page;
                            end
                            K_ALIGNED: begin
                                r_mode <= M_ALIGN;
                                r_cand <= PW'(i_align);
                                r_ptr  <= PW'(i_align);
                                r_we   <= PW'(i_align) + PW'(i_count);
                                r_ok   <= 1'b0;
                                r_rp   <= '0;
                            end
                            K_EXTEND: begin
                                r_rp <= i_page;
                                r_ok <= (i_count <= i_prev_count);
                                if (i_count <= i_prev_count) begin
                                    r_wp   <= PW'(i_page);
                                    r_we   <= PW'(i_page) + PW'(i_count);
                                    r_wval <= 1'b1;
                                end else begin
                                    r_mode <= M_EXT;
                                    r_ptr  <= PW'(i_page) + PW'(i_prev_count);
                                    r_we   <= PW'(i_page) + PW'(i_count);
                                end
                            end
                            K_CLRSTAT: begin
                                r_ok    <= 1'b1;
                                r_rp    <= '0;
                                r_flags <= '0;
                            end
                            default: begin
                                r_ok <= 1'b0;
                                r_rp <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pend <= 1'b1;
                    r_chk  <= scan_addr;
                    r_ptr  <= scan_addr + 1'b1;
                    if (r_pend) begin
                        unique case (r_mode)
                            M_FIT: begin
                                r_run <= used ? '0 : r_run + 1'b1;
                                r_any <= r_any | free_now;
                                if (fit_hit) begin
                                    r_at   <= r_chk + 1'b1 - PW'(r_count);
                                    r_wp   <= r_chk + 1'b1 - PW'(r_count);
                                    r_we   <= r_chk + 1'b1;
                                    r_wval <= 1'b1;
                                    r_ok   <= 1'b1;
                                    r_rp   <= 12'(r_chk + 1'b1 - PW'(r_count));
                                    if (r_kind == K_EXTEND) begin
                                        r_mv   <= 1'b1;
                                        r_move <= 1'b1;
                                    end
                                end else if (fit_end) begin
                                    if (r_any | free_now) r_flags[FLAG_NOSIZE] <= 1'b1;
                                    else r_flags[FLAG_NOFREE] <= 1'b1;
                                end
                            end
                            M_ALIGN: begin
                                if (al_hit) begin
                                    r_wp   <= r_cand;
                                    r_wval <= 1'b1;
                                    r_ok   <= 1'b1;
                                    r_rp   <= r_cand[11:0];
                                end else if (redirect) begin
                                    r_cand <= cand_next;
                                    r_we   <= cand_next + PW'(r_count);
                                end
                            end
                            M_EXT: begin
                                if (ext_hit) begin
                                    r_wp   <= PW'(r_page);
                                    r_wval <= 1'b1;
                                    r_ok   <= 1'b1;
                                end else if (redirect) begin
                                    r_mode <= M_FIT;
                                    r_run  <= '0;
                                    r_any  <= 1'b0;
                                end
                            end
                            default: r_mode <= M_FIT;
                        endcase
                    end
                end
                S_FILL: begin
                    if (!done_w) begin
                        r_wp <= r_wp + 1'b1;
                    end else if (r_move) begin
                        // release the old run, skipping pages of the new one
                        r_wp   <= PW'(r_page);
                        r_we   <= PW'(r_page) + PW'(r_prev);
                        r_wval <= 1'b0;
                        r_move <= 1'b0;
                    end
                end
                S_FREE: begin
                    if (!done_w) r_wp <= r_wp + 1'b1;
                end
                S_DONE:  r_pend <= 1'b0;
                default: r_pend <= 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpa_checker.sv -----
// port-level checks for the bitmap page allocator, bound to the top level
// imports bpa_pkg; none of its items are used by these checks
`default_nettype none

module bpa_checker
    import bpa_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire logic o_ok,
    input wire logic o_moved,
    input wire logic o_no_free_space,
    input wire logic o_size_unavailable
);

    // an accepted transaction raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result ends the transaction
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy after result strobe");

    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_moved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_moved) |-> o_ok)
        else $error("moved without success");

    // sticky flags hold while idle with no request; they drop only on a status clear or reset
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> ($stable(o_no_free_space) && $stable(o_size_unavailable)))
        else $error("status flags changed while idle");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_ok               (o_ok),
    .o_moved            (o_moved),
    .o_no_free_space    (o_no_free_space),
    .o_size_unavailable (o_size_unavailable)
);

`default_nettype wire
